/* src/ats_pkg.sv */
// ---------------------------------------------------------------------------
// ats_pkg
// Shared types and constants for the terminal screen block.
// ---------------------------------------------------------------------------
package ats_pkg;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] FIN_H    = 8'h48;
  localparam logic [7:0] FIN_F    = 8'h66;
  localparam logic [7:0] FIN_J    = 8'h4a;
  localparam logic [7:0] FIN_K    = 8'h4b;
  localparam logic [13:0] NUM_MAX = 14'd9999;
  localparam logic [11:0] COL_MAX = 12'd4095;

  typedef enum logic [1:0] {
    EP_IDLE = 2'd0,
    EP_ESC  = 2'd1,
    EP_CSI  = 2'd2
  } esc_phase_t;

  typedef enum logic [2:0] {
    PS_NONE   = 3'd0,
    PS_PLUS   = 3'd1,
    PS_NEG    = 3'd2,
    PS_DIGITS = 3'd3,
    PS_DONE   = 3'd4,
    PS_SPACE  = 3'd5
  } parse_stage_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_PAD    = 3'd2,
    ST_CLEAR  = 3'd3,
    ST_RDWAIT = 3'd4,
    ST_OUT    = 3'd5
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic decode;    // interpret captured item (one cycle)
    logic pad_step;  // write one pad space
    logic clr_step;  // clear one row length
    logic clr_start;
    logic rd_issue;  // issue cell read
    logic out_load;  // fill output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_pad;
    logic need_clear;
    logic pad_last;
    logic clr_last;
    logic is_read;
  } dp_stat_t;

endpackage

/* src/ats_if.sv */
// ---------------------------------------------------------------------------
// ats_in_if / ats_out_if
// Valid/ready channels for stream items and results.
// ---------------------------------------------------------------------------
interface ats_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] stream_byte;
  logic [4:0] read_row;
  logic [7:0] read_col;
  modport source (output valid, cmd, stream_byte, read_row, read_col, input ready);
  modport sink (input valid, cmd, stream_byte, read_row, read_col, output ready);
endinterface

interface ats_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_char;
  logic [7:0]  row_length;
  logic [4:0]  cursor_line;
  logic [11:0] cursor_column;
  logic        escape_pending;
  modport source (output valid, cell_char, row_length, cursor_line, cursor_column,
                  escape_pending, input ready);
  modport sink (input valid, cell_char, row_length, cursor_line, cursor_column,
                escape_pending, output ready);
endinterface

/* src/ats_ctl.sv */
// ---------------------------------------------------------------------------
// ats_ctl
// Sequencer: capture, decode, pad/clear sweeps, read wait, result handoff.
// ---------------------------------------------------------------------------
module ats_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_free,
  input  ats_pkg::dp_stat_t stat,
  output logic              busy,
  output ats_pkg::ctl_cmd_t cmd
);

  ats_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ats_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ats_pkg::ST_IDLE:   if (in_fire) state_nxt = ats_pkg::ST_DECODE;
      ats_pkg::ST_DECODE: begin
        priority if (stat.is_read) state_nxt = ats_pkg::ST_RDWAIT;
        else if (stat.need_clear)  state_nxt = ats_pkg::ST_CLEAR;
        else if (stat.need_pad)    state_nxt = ats_pkg::ST_PAD;
        else                       state_nxt = ats_pkg::ST_OUT;
      end
      ats_pkg::ST_PAD:    if (stat.pad_last) state_nxt = ats_pkg::ST_OUT;
      ats_pkg::ST_CLEAR:  if (stat.clr_last) state_nxt = ats_pkg::ST_OUT;
      ats_pkg::ST_RDWAIT: state_nxt = ats_pkg::ST_OUT;
      ats_pkg::ST_OUT:    if (out_free) state_nxt = ats_pkg::ST_IDLE;
      default:            state_nxt = ats_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ats_pkg::ST_IDLE);
    unique case (state_r)
      ats_pkg::ST_IDLE:   cmd.load = in_fire;
      ats_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        cmd.rd_issue = stat.is_read;
        cmd.clr_start = stat.need_clear;
      end
      ats_pkg::ST_PAD:    cmd.pad_step = 1'b1;
      ats_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      ats_pkg::ST_RDWAIT: ;
      ats_pkg::ST_OUT:    cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

/* src/ats_dp.sv */
// ---------------------------------------------------------------------------
// ats_dp
// Cursor, escape parser, row lengths and the cell memory.
// ---------------------------------------------------------------------------
module ats_dp #(
  parameter int ROWS    = 24,
  parameter int COLS    = 128,
  parameter int ESC_CAP = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ats_pkg::ctl_cmd_t cmd,
  output ats_pkg::dp_stat_t stat,
  input  logic              i_cmd,
  input  logic [7:0]        i_byte,
  input  logic [4:0]        i_row,
  input  logic [7:0]        i_col,
  output logic [7:0]        o_char,
  output logic [7:0]        o_len,
  output logic [4:0]        o_line,
  output logic [11:0]       o_column,
  output logic              o_esc
);

  localparam int RW = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW = $clog2(DEPTH);

  // captured item
  logic       cmd_r;
  logic [7:0] byte_r, col_r;
  logic [4:0] row_r;

  logic [4:0]  line_r;
  logic [11:0] column_r;
  ats_pkg::esc_phase_t   phase_r;
  logic [5:0]  ecount_r;
  logic [13:0] num1_r, num2_r;
  ats_pkg::parse_stage_t ps1_r, ps2_r;
  logic        sep_r, two_r;
  logic [7:0]  len_r [ROWS];

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata_r;
  logic        rd_ok_r;
  logic [7:0]  rlen_r;

  // pad and clear sweeps
  logic [7:0]  pad_pos_r;
  logic [RW-1:0] pad_row_r;
  logic [7:0]  pad_end_r;
  logic [RW-1:0] clr_idx_r;

  // --- number field step ---
  function automatic void num_step(input logic [13:0] n, input ats_pkg::parse_stage_t s,
                                   input logic [7:0] b, output logic [13:0] no,
                                   output ats_pkg::parse_stage_t so);
    logic dig, sp;
    logic [17:0] v;
    logic [13:0] d;
    dig = (b >= ats_pkg::CH_ZERO) && (b <= ats_pkg::CH_NINE);
    sp = (b == ats_pkg::CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0d));
    d = 14'(b - ats_pkg::CH_ZERO);
    no = n;
    so = s;
    v = 18'(n) * 18'd10 + 18'(d);
    unique case (s)
      ats_pkg::PS_NONE, ats_pkg::PS_SPACE: begin
        priority if (s == ats_pkg::PS_NONE && b == ats_pkg::CH_QUEST) begin
          no = '0; so = ats_pkg::PS_DONE;
        end else if (sp) so = ats_pkg::PS_SPACE;
        else if (b == ats_pkg::CH_PLUS) so = ats_pkg::PS_PLUS;
        else if (b == ats_pkg::CH_MINUS) so = ats_pkg::PS_NEG;
        else if (dig) begin no = d; so = ats_pkg::PS_DIGITS; end
        else so = ats_pkg::PS_DONE;
      end
      ats_pkg::PS_PLUS: begin
        if (dig) begin no = d; so = ats_pkg::PS_DIGITS; end
        else so = ats_pkg::PS_DONE;
      end
      ats_pkg::PS_DIGITS: begin
        if (dig) no = (v > 18'(ats_pkg::NUM_MAX)) ? ats_pkg::NUM_MAX : v[13:0];
        else so = ats_pkg::PS_DONE;
      end
      default: ;
    endcase
  endfunction

  // --- decode ---
  logic in_row_ok;
  logic [RW-1:0] cur_ri;
  logic [7:0] cur_len;
  logic [11:0] idx;
  logic put_ok;
  logic is_final;
  logic [13:0] n1n, n2n;
  ats_pkg::parse_stage_t p1n, p2n;
  logic [13:0] tr, tc;
  logic [4:0]  tline;
  logic [11:0] tcol;

  always_comb begin
    in_row_ok = (line_r >= 5'd1) && (32'(line_r) <= ROWS);
    cur_ri = RW'(line_r - 5'd1);
    cur_len = len_r[cur_ri];
    idx = column_r - 12'd1;
    put_ok = in_row_ok && (32'(idx) < COLS);
    is_final = (byte_r >= ats_pkg::FINAL_LO) && (byte_r <= ats_pkg::FINAL_HI);
    num_step(num1_r, ps1_r, byte_r, n1n, p1n);
    num_step(num2_r, ps2_r, byte_r, n2n, p2n);
    tr = (num1_r < 14'd1) ? 14'd1 : num1_r;
    if (32'(tr) > ROWS) tr = 14'(ROWS);
    tc = sep_r ? num2_r : 14'd1;
    if (tc < 14'd1) tc = 14'd1;
    if (tc > 14'(ats_pkg::COL_MAX)) tc = 14'(ats_pkg::COL_MAX);
    tline = tr[4:0];
    tcol = tc[11:0];
  end

  wire printable = (phase_r == ats_pkg::EP_IDLE) && (byte_r >= ats_pkg::CH_SPACE)
                   && (byte_r != ats_pkg::CH_DEL);
  wire clr_all = (phase_r == ats_pkg::EP_CSI) && is_final && (byte_r == ats_pkg::FIN_J)
                 && (ecount_r == 6'd1 || two_r) && (32'(ecount_r) + 1 < ESC_CAP);

  always_comb begin
    stat.is_read = cmd_r;
    stat.need_pad = !cmd_r && printable && put_ok && (12'(cur_len) < idx);
    stat.need_clear = !cmd_r && clr_all;
    stat.pad_last = (pad_pos_r + 8'd1 >= pad_end_r);
    stat.clr_last = (32'(clr_idx_r) == ROWS - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= i_cmd; byte_r <= i_byte; row_r <= i_row; col_r <= i_col;
    end
  end

  // cell memory: one write port, one read port
  logic          mwe;
  logic [AW-1:0] mwa, mra;
  logic [7:0]    mwd;
  always_comb begin
    mwe = 1'b0; mwa = '0; mwd = ats_pkg::CH_SPACE;
    mra = AW'(32'(row_r - 5'd1) * COLS + 32'(col_r - 8'd1));
    if (cmd.pad_step) begin
      mwe = 1'b1;
      mwa = AW'(32'(pad_row_r) * COLS + 32'(pad_pos_r));
    end else if (cmd.decode && !cmd_r && printable && put_ok) begin
      mwe = 1'b1;
      mwa = AW'(32'(cur_ri) * COLS + 32'(idx));
      mwd = byte_r;
    end
  end
  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    if (cmd.rd_issue) rdata_r <= mem[mra];
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      pad_row_r <= cur_ri;
      pad_pos_r <= cur_len;
      pad_end_r <= idx[7:0];
    end else if (cmd.pad_step) pad_pos_r <= pad_pos_r + 8'd1;
    if (cmd.clr_start) clr_idx_r <= '0;
    else if (cmd.clr_step) clr_idx_r <= clr_idx_r + RW'(1);
    if (cmd.rd_issue) begin
      if ((row_r >= 5'd1) && (32'(row_r) <= ROWS)) begin
        rlen_r <= len_r[RW'(row_r - 5'd1)];
        rd_ok_r <= (col_r >= 8'd1) && (col_r <= len_r[RW'(row_r - 5'd1)])
                   && (32'(col_r) <= COLS);
      end else begin
        rlen_r <= '0; rd_ok_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 5'd1; column_r <= 12'd1; phase_r <= ats_pkg::EP_IDLE;
      ecount_r <= '0; num1_r <= '0; num2_r <= '0;
      ps1_r <= ats_pkg::PS_NONE; ps2_r <= ats_pkg::PS_NONE;
      sep_r <= 1'b0; two_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) len_r[i] <= '0;
    end else begin
      if (cmd.clr_step) len_r[clr_idx_r] <= '0;
      if (cmd.decode && !cmd_r) begin
        if (phase_r != ats_pkg::EP_IDLE) begin
          if (32'(ecount_r) + 1 >= ESC_CAP) begin
            phase_r <= ats_pkg::EP_IDLE; ecount_r <= '0;
          end else if (phase_r == ats_pkg::EP_ESC) begin
            if (byte_r == ats_pkg::CH_LBRK) begin
              phase_r <= ats_pkg::EP_CSI; ecount_r <= 6'd1;
              num1_r <= '0; num2_r <= '0;
              ps1_r <= ats_pkg::PS_NONE; ps2_r <= ats_pkg::PS_NONE;
              sep_r <= 1'b0; two_r <= 1'b0;
            end else begin
              phase_r <= ats_pkg::EP_IDLE; ecount_r <= '0;
            end
          end else if (is_final) begin
            phase_r <= ats_pkg::EP_IDLE; ecount_r <= '0;
            priority if (byte_r == ats_pkg::FIN_H || byte_r == ats_pkg::FIN_F) begin
              line_r <= tline; column_r <= tcol;
              if (tcol == 12'd1) len_r[RW'(tline - 5'd1)] <= '0;
            end else if (clr_all) begin
              line_r <= 5'd1; column_r <= 12'd1;
            end else if (byte_r == ats_pkg::FIN_K) begin
              if (in_row_ok) len_r[cur_ri] <= '0;
            end
          end else begin
            if (ecount_r == 6'd1 && byte_r == ats_pkg::CH_TWO) two_r <= 1'b1;
            ecount_r <= ecount_r + 6'd1;
            priority if (sep_r) begin num2_r <= n2n; ps2_r <= p2n; end
            else if (byte_r == ats_pkg::CH_SEMI) sep_r <= 1'b1;
            else begin num1_r <= n1n; ps1_r <= p1n; end
          end
        end else if (byte_r == ats_pkg::CH_ESC) begin
          phase_r <= ats_pkg::EP_ESC; ecount_r <= '0;
        end else if (byte_r == ats_pkg::CH_CR) column_r <= 12'd1;
        else if (byte_r == ats_pkg::CH_LF) begin
          if (32'(line_r) < ROWS) line_r <= line_r + 5'd1;
          column_r <= 12'd1;
        end else if (printable && put_ok) begin
          if (12'(cur_len) <= idx) len_r[cur_ri] <= 8'(idx + 12'd1);
          if (column_r != ats_pkg::COL_MAX) column_r <= column_r + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_char <= (cmd_r && rd_ok_r) ? rdata_r : 8'd0;
      o_len <= cmd_r ? rlen_r : 8'd0;
      o_line <= line_r;
      o_column <= column_r;
      o_esc <= (phase_r != ats_pkg::EP_IDLE);
    end
  end

endmodule

/* src/ansi_terminal_screen.sv */
// ---------------------------------------------------------------------------
// ansi_terminal_screen
// Terminal byte stream into a character screen, with cell readback.
// ---------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | cmd, stream_byte, read_row, read_col
// out_    | out | cell_char, row_length, cursor_line, cursor_column, escape_pending
//
// An item may add a sweep: a gap before a printable byte is padded one space
// per write (one memory write port), and a screen clear sweeps all ROWS row
// lengths. A read uses a registered memory read. One item at a time.
// rst_n is synchronous; the cell memory is not cleared, row lengths are.
// A stalled result holds in the output register; one more item is taken and
// processed, then waits until the register is free.
module ansi_terminal_screen #(
  parameter int ROWS    = 24,
  parameter int COLS    = 128,
  parameter int ESC_CAP = 32
) (
  input logic    clk,
  input logic    rst_n,
  ats_in_if.sink   in_ch,
  ats_out_if.source out_ch
);

  ats_pkg::ctl_cmd_t cmd;
  ats_pkg::dp_stat_t stat;
  logic busy, ovalid_r;

  wire in_fire = in_ch.valid && in_ch.ready;
  wire out_free = !ovalid_r || out_ch.ready;
  assign in_ch.ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
  end
  assign out_ch.valid = ovalid_r;

  ats_ctl u_ctl (
    .clk, .rst_n, .in_fire, .out_free, .stat, .busy, .cmd
  );

  ats_dp #(.ROWS(ROWS), .COLS(COLS), .ESC_CAP(ESC_CAP)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .i_cmd(in_ch.cmd), .i_byte(in_ch.stream_byte),
    .i_row(in_ch.read_row), .i_col(in_ch.read_col),
    .o_char(out_ch.cell_char), .o_len(out_ch.row_length),
    .o_line(out_ch.cursor_line), .o_column(out_ch.cursor_column),
    .o_esc(out_ch.escape_pending)
  );

endmodule

/* src/ats_checker.sv */
// ---------------------------------------------------------------------------
// ats_checker
// Port-level checks on the screen block.
// ---------------------------------------------------------------------------
module ats_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  cursor_line,
  input logic [11:0] cursor_column
);

  // a busy block stays closed while its result is held
  a_no_accept_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !in_ready |=> !in_ready)
    else $error("input reopened while result held");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second accept while busy");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cursor_line != 5'd0 && cursor_column != 12'd0)
    else $error("cursor zero");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_column)
    && $stable(cursor_line))
    else $error("result dropped");

endmodule

bind ansi_terminal_screen ats_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .cursor_line(out_ch.cursor_line), .cursor_column(out_ch.cursor_column)
);
